// ===== src/lbcd_pkg.sv =====
package lbcd_pkg;

  // Default sizes
  localparam int unsigned DefEntries   = 16;
  localparam int unsigned DefStampBits = 32;

  localparam int unsigned IdBits    = 64;
  localparam int unsigned SlotBits  = 4;
  localparam int unsigned CountBits = 32;

  // Request kinds
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_UPDATE  = 3'd2,
    ST_INSERT  = 3'd3,
    ST_REPLACE = 3'd4,
    ST_REJECT  = 3'd5
  } status_e;

  typedef struct packed {
    logic [IdBits-1:0] node_id;
    logic [IdBits-1:0] block_id;
  } key_t;

  typedef struct packed {
    logic              req_type;
    logic [IdBits-1:0] node_id;
    logic [IdBits-1:0] block_id;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [SlotBits-1:0]  slot;
    logic [CountBits-1:0] query_total;
    logic [CountBits-1:0] hit_total;
  } rsp_t;

  // Finished lookup handed from the controller to the output stage
  typedef struct packed {
    status_e             status;
    logic [SlotBits-1:0] slot;
    logic                is_get;
  } done_t;

endpackage

// ===== src/lbcd_tag_mem.sv =====
module lbcd_tag_mem import lbcd_pkg::*; #(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned STAMP_BITS = DefStampBits,
  localparam int unsigned IdxW      = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  key_t                  wkey_i,
  input  logic [STAMP_BITS-1:0] wstamp_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output key_t                  rkey_o,
  output logic [STAMP_BITS-1:0] rstamp_o
);

  key_t                  key_mem   [ENTRIES];
  logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]   <= wkey_i;
      stamp_mem[waddr_i] <= wstamp_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o   <= key_mem[raddr_i];
      rstamp_o <= stamp_mem[raddr_i];
    end
  end

endmodule

// ===== src/lbcd_ctrl.sv =====
module lbcd_ctrl import lbcd_pkg::*; #(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned STAMP_BITS = DefStampBits,
  localparam int unsigned IdxW      = $clog2(ENTRIES),
  localparam int unsigned CntW      = $clog2(ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_req_i,
  output logic                  done_valid_o,
  input  logic                  done_ready_i,
  output done_t                 done_o,
  output logic                  mem_re_o,
  output logic [IdxW-1:0]       mem_raddr_o,
  input  key_t                  mem_rkey_i,
  input  logic [STAMP_BITS-1:0] mem_rstamp_i,
  output logic                  mem_we_o,
  output logic [IdxW-1:0]       mem_waddr_o,
  output key_t                  mem_wkey_o,
  output logic [STAMP_BITS-1:0] mem_wstamp_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam logic [CntW-1:0]       FullCount = CntW'(ENTRIES);
  localparam logic [STAMP_BITS-1:0] StampMax  = '1;

  logic [1:0]            state_q, state_d;
  req_t                  req_q;
  logic [CntW-1:0]       filled_q;
  logic [STAMP_BITS-1:0] time_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  found_q;
  logic [IdxW-1:0]       found_idx_q;
  logic [IdxW-1:0]       min_idx_q;
  logic [STAMP_BITS-1:0] min_stamp_q;
  status_e               res_status_q, res_status_d;
  logic [IdxW-1:0]       res_idx_d;

  logic in_fire;
  logic zero_id;
  logic scan_last;
  logic scan_match;
  logic put_wr_insert;
  key_t req_key;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign zero_id      = (in_req_i.node_id == '0) || (in_req_i.block_id == '0);
  assign req_key      = '{node_id: req_q.node_id, block_id: req_q.block_id};
  assign scan_match   = (mem_rkey_i == req_key);
  assign scan_last    = ((CntW'(rd_idx_q) + CntW'(1)) == filled_q);
  assign put_wr_insert = (filled_q != FullCount);

  // Issue one tag read per cycle while walking the filled entries
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    if (state_q == S_IDLE) begin
      mem_re_o = in_fire && (filled_q != '0) &&
                 !((in_req_i.req_type == REQ_PUT) && zero_id);
    end else if (state_q == S_SCAN) begin
      mem_re_o    = !scan_last && !scan_match;
      mem_raddr_o = rd_idx_q + IdxW'(1);
    end
  end

  // Resolve the request and write the entry back on a get hit or a put
  always_comb begin
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wkey_o   = req_key;
    mem_wstamp_o = time_q;
    res_status_d = ST_MISS;
    res_idx_d    = '0;
    if (req_q.req_type == REQ_GET) begin
      if (found_q) begin
        mem_we_o     = 1'b1;
        res_status_d = ST_HIT;
        res_idx_d    = found_idx_q;
      end
    end else if (found_q) begin
      mem_we_o     = 1'b1;
      res_status_d = ST_UPDATE;
      res_idx_d    = found_idx_q;
    end else if (put_wr_insert) begin
      mem_we_o     = 1'b1;
      res_status_d = ST_INSERT;
      res_idx_d    = filled_q[IdxW-1:0];
    end else begin
      mem_we_o     = 1'b1;
      res_status_d = ST_REPLACE;
      res_idx_d    = min_idx_q;
    end
    mem_waddr_o = res_idx_d;
    if (state_q != S_DECIDE) begin
      mem_we_o = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_req_i.req_type == REQ_PUT) && zero_id) begin
            state_d = S_DONE;
          end else if (filled_q == '0) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_match || scan_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: state_d = S_DONE;
      S_DONE: begin
        if (done_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state: sequencer, fill count, time counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      filled_q <= '0;
      time_q   <= STAMP_BITS'(1);
    end else begin
      state_q <= state_d;
      if (mem_we_o) begin
        if (time_q != StampMax) begin
          time_q <= time_q + STAMP_BITS'(1);
        end
        if (res_status_d == ST_INSERT) begin
          filled_q <= filled_q + CntW'(1);
        end
      end
    end
  end

  // Request, scan results and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q        <= in_req_i;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      res_status_q <= ST_REJECT;
    end
    if (state_q == S_SCAN) begin
      if (scan_match) begin
        found_q     <= 1'b1;
        found_idx_q <= rd_idx_q;
      end
      if ((rd_idx_q == '0) || (mem_rstamp_i < min_stamp_q)) begin
        min_idx_q   <= rd_idx_q;
        min_stamp_q <= mem_rstamp_i;
      end
      rd_idx_q <= rd_idx_q + IdxW'(1);
    end
    if (state_q == S_DECIDE) begin
      res_status_q <= res_status_d;
      found_idx_q  <= res_idx_d;
    end
  end

  assign done_valid_o  = (state_q == S_DONE);
  assign done_o.status = res_status_q;
  assign done_o.slot   = ((res_status_q == ST_MISS) || (res_status_q == ST_REJECT)) ?
                         '0 : SlotBits'(found_idx_q);
  assign done_o.is_get = (req_q.req_type == REQ_GET);

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FullCount)
    else $error("fill count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(rd_idx_q) < filled_q))
    else $error("scan past filled entries");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (time_q >= $past(time_q)))
    else $error("time counter went backward");

  a_replace_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_valid_o && (done_o.status == ST_REPLACE)) |-> (filled_q == FullCount))
    else $error("replacement while free entries remain");

endmodule

// ===== src/lru_block_cache_directory.sv =====
// Cache directory for (node id, block id) keys with least-recently-used
// replacement. Block data lives outside; the returned slot addresses it.
//
// Channels: requests enter on in_valid_i/in_ready_o carrying in_req_i
// (get or put plus the key); one result item per request leaves on
// out_valid_o/out_ready_i carrying out_rsp_o (status, slot, running
// get and hit totals).
// Timing: the controller reads one stored tag per cycle from a tag/stamp
// memory with one read and one write port, stopping at the first match.
// A request walks up to ENTRIES filled entries before it is decided; a
// rejected put skips the walk. One request is in work at a time, so a
// new request is not accepted until the last one has left the
// controller.
// Reset: empties the directory, sets the time counter to one and clears
// the totals; no memory clearing pass is needed.
// Stalls: the result register holds its item while out_ready_i is low;
// the next request is still accepted and worked, and waits only at its
// own completion until the register frees.
module lru_block_cache_directory import lbcd_pkg::*; #(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned STAMP_BITS = DefStampBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [CountBits-1:0] CountMax = '1;

  logic                  mem_re, mem_we;
  logic [IdxW-1:0]       mem_raddr, mem_waddr;
  key_t                  mem_rkey, mem_wkey;
  logic [STAMP_BITS-1:0] mem_rstamp, mem_wstamp;

  logic                 done_valid, done_ready, done_fire;
  done_t                done;
  logic                 out_valid_q;
  rsp_t                 out_rsp_q;
  logic [CountBits-1:0] query_q, query_d;
  logic [CountBits-1:0] hit_q, hit_d;

  lbcd_tag_mem #(
    .ENTRIES    (ENTRIES),
    .STAMP_BITS (STAMP_BITS)
  ) u_tag_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wkey_i   (mem_wkey),
    .wstamp_i (mem_wstamp),
    .re_i     (mem_re),
    .raddr_i  (mem_raddr),
    .rkey_o   (mem_rkey),
    .rstamp_o (mem_rstamp)
  );

  lbcd_ctrl #(
    .ENTRIES    (ENTRIES),
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .done_o       (done),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rkey_i   (mem_rkey),
    .mem_rstamp_i (mem_rstamp),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wkey_o   (mem_wkey),
    .mem_wstamp_o (mem_wstamp)
  );

  assign done_ready = !out_valid_q || out_ready_i;
  assign done_fire  = done_valid && done_ready;

  // Saturating get and hit totals
  always_comb begin
    query_d = query_q;
    hit_d   = hit_q;
    if (done.is_get && (query_q != CountMax)) begin
      query_d = query_q + CountBits'(1);
    end
    if (done.is_get && (done.status == ST_HIT) && (hit_q != CountMax)) begin
      hit_d = hit_q + CountBits'(1);
    end
  end

  // Hold the result until taken; the totals advance only with finished gets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      query_q     <= '0;
      hit_q       <= '0;
    end else begin
      if (done_fire) begin
        out_valid_q <= 1'b1;
        query_q     <= query_d;
        hit_q       <= hit_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_rsp_q.status      <= done.status;
      out_rsp_q.slot        <= done.slot;
      out_rsp_q.query_total <= query_d;
      out_rsp_q.hit_total   <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
